// ----- hdl/ccc_pkg.sv -----
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared widths, reset values, register indexes and pipeline item types of
// the chromaticity color classifier.
// ----------------------------------------------------------------------------
package ccc_pkg;

    localparam int CH_W      = 8;               // one color channel
    localparam int NUM_CH    = 3;               // blue, green, red
    localparam int SUM_W     = 10;              // b + g + r <= 765
    localparam int NUM_W     = 16;              // c * 255 <= 65025
    localparam int QUOT_W    = 8;               // normalized channel
    localparam int SH_W      = SUM_W + QUOT_W - 1;  // divisor shifted by the top quotient bit
    localparam int SQ_W      = 2 * QUOT_W;      // square of an 8-bit difference
    localparam int DIST_W    = SQ_W + 1;        // sum of two squares
    localparam int THR_W     = 10;
    localparam int TGT_W     = 8;
    localparam int RAD_W     = 18;

    localparam int NORM_SCALE = 255;
    localparam int DIV_BITS_DEFAULT = 2;        // quotient bits per divider stage

    localparam int CH_B = 0;
    localparam int CH_G = 1;
    localparam int CH_R = 2;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [THR_W-1:0] DARK_THRESHOLD_RST = THR_W'(125);
    localparam logic [TGT_W-1:0] TARGET_GREEN_RST   = TGT_W'(40);
    localparam logic [TGT_W-1:0] TARGET_RED_RST     = TGT_W'(180);
    localparam logic [RAD_W-1:0] RADIUS_SQUARED_RST = RAD_W'(3600);

    typedef enum logic [1:0] {
        REG_DARK_THRESHOLD = 2'd0,
        REG_TARGET_GREEN   = 2'd1,
        REG_TARGET_RED     = 2'd2,
        REG_RADIUS_SQUARED = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [THR_W-1:0] dark_threshold;
        logic [TGT_W-1:0] target_green;
        logic [TGT_W-1:0] target_red;
        logic [RAD_W-1:0] radius_squared;
    } t_cfg;

    // One pixel on its way through the divider: partial remainders and
    // quotients of the three channels share one divisor, the channel sum.
    typedef struct packed {
        logic [NUM_CH-1:0][NUM_W-1:0]  rem;
        logic [NUM_CH-1:0][QUOT_W-1:0] quot;
        logic [SUM_W-1:0]              sum;
        logic                          dark;
    } t_div_item;

endpackage

// ----- hdl/ccc_pix_if.sv -----
// ----------------------------------------------------------------------------
// ccc_pix_if
// Pixel request channel: valid/ready handshake with one BGR pixel.
// ----------------------------------------------------------------------------
interface ccc_pix_if import ccc_pkg::*; ();

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] blue_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] red_in;

    modport source (output valid, output blue_in, output green_in, output red_in,
                    input ready);
    modport sink   (input valid, input blue_in, input green_in, input red_in,
                    output ready);

endinterface

// ----- hdl/ccc_res_if.sv -----
// ----------------------------------------------------------------------------
// ccc_res_if
// Result request channel: normalized pixel and target mask bit.
// ----------------------------------------------------------------------------
interface ccc_res_if import ccc_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [QUOT_W-1:0] norm_blue;
    logic [QUOT_W-1:0] norm_green;
    logic [QUOT_W-1:0] norm_red;
    logic              in_target;

    modport source (output valid, output norm_blue, output norm_green, output norm_red,
                    output in_target, input ready);
    modport sink   (input valid, input norm_blue, input norm_green, input norm_red,
                    input in_target, output ready);

endinterface

// ----- hdl/ccc_front.sv -----
// ----------------------------------------------------------------------------
// ccc_front
// First pipeline stage: channel sum, dark decision and the scaled numerators
// c * 255 that enter the divider.
// ----------------------------------------------------------------------------
module ccc_front import ccc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [CH_W-1:0]  i_blue,
    input  logic [CH_W-1:0]  i_green,
    input  logic [CH_W-1:0]  i_red,
    input  t_cfg             i_cfg,
    output logic             o_ready,
    output logic             o_valid,
    output t_div_item        o_item,
    input  logic             i_ready
);

    logic      r_valid;
    t_div_item r_item;
    t_div_item n_item;
    logic [SUM_W-1:0] sum;

    assign sum = SUM_W'(i_blue) + SUM_W'(i_green) + SUM_W'(i_red);

    always_comb begin
        n_item      = '0;
        n_item.sum  = sum;
        n_item.dark = (sum < i_cfg.dark_threshold) || (sum == '0);
        n_item.rem[CH_B] = NUM_W'(i_blue)  * NUM_W'(NORM_SCALE);
        n_item.rem[CH_G] = NUM_W'(i_green) * NUM_W'(NORM_SCALE);
        n_item.rem[CH_R] = NUM_W'(i_red)   * NUM_W'(NORM_SCALE);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- hdl/ccc_div_stage.sv -----
// ----------------------------------------------------------------------------
// ccc_div_stage
// One stage of the pipelined restoring divider. It resolves BITS quotient
// bits of all three channels against the shared channel sum.
// ----------------------------------------------------------------------------
module ccc_div_stage import ccc_pkg::*; #(
    parameter int STAGE_IDX = 0,
    parameter int BITS      = DIV_BITS_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_div_item i_item,
    output logic      o_ready,
    output logic      o_valid,
    output t_div_item o_item,
    input  logic      i_ready
);

    logic      r_valid;
    t_div_item r_item;
    t_div_item n_item;

    // The numerator is at most 255 times the divisor, so the remainder that
    // enters the step for quotient bit k is always below sum << (k + 1).
    always_comb begin
        logic [NUM_W-1:0]  rem;
        logic [QUOT_W-1:0] quot;
        logic [SH_W-1:0]   dsh;
        n_item = i_item;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            rem  = i_item.rem[ch];
            quot = i_item.quot[ch];
            for (int j = 0; j < BITS; j++) begin
                dsh = SH_W'(i_item.sum) << (QUOT_W - 1 - STAGE_IDX * BITS - j);
                if (SH_W'(rem) >= dsh) begin
                    rem  = NUM_W'(SH_W'(rem) - dsh);
                    quot = {quot[QUOT_W-2:0], 1'b1};
                end else begin
                    quot = {quot[QUOT_W-2:0], 1'b0};
                end
            end
            n_item.rem[ch]  = rem;
            n_item.quot[ch] = quot;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- hdl/ccc_dist.sv -----
// ----------------------------------------------------------------------------
// ccc_dist
// Last two pipeline stages: dark masking, squared distance terms to the
// target point, then the sum and the radius compare into the output register.
// ----------------------------------------------------------------------------
module ccc_dist import ccc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_div_item         i_item,
    input  t_cfg              i_cfg,
    output logic              o_ready,
    output logic              o_valid,
    output logic [QUOT_W-1:0] o_norm_blue,
    output logic [QUOT_W-1:0] o_norm_green,
    output logic [QUOT_W-1:0] o_norm_red,
    output logic              o_in_target,
    input  logic              i_ready
);

    // Square stage.
    logic              r_a_valid;
    logic [QUOT_W-1:0] r_a_nb, r_a_ng, r_a_nr;
    logic [SQ_W-1:0]   r_a_sq_g, r_a_sq_r;
    logic [QUOT_W-1:0] n_a_nb, n_a_ng, n_a_nr;
    logic [QUOT_W-1:0] dg, dr;
    logic              a_ready;

    // Compare stage, which is also the output register.
    logic              r_b_valid;
    logic [QUOT_W-1:0] r_b_nb, r_b_ng, r_b_nr;
    logic              r_b_hit;
    logic [DIST_W-1:0] sq_dist;

    always_comb begin
        if (i_item.dark) begin
            n_a_nb = '0;
            n_a_ng = '0;
            n_a_nr = '0;
        end else begin
            n_a_nb = i_item.quot[CH_B];
            n_a_ng = i_item.quot[CH_G];
            n_a_nr = i_item.quot[CH_R];
        end
        dg = (n_a_ng >= i_cfg.target_green) ? (n_a_ng - i_cfg.target_green)
                                            : (i_cfg.target_green - n_a_ng);
        dr = (n_a_nr >= i_cfg.target_red) ? (n_a_nr - i_cfg.target_red)
                                          : (i_cfg.target_red - n_a_nr);
    end

    assign o_ready = !r_a_valid || a_ready;
    assign a_ready = !r_b_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_a_valid <= i_valid;
            end
            if (a_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_a_nb   <= n_a_nb;
            r_a_ng   <= n_a_ng;
            r_a_nr   <= n_a_nr;
            r_a_sq_g <= SQ_W'(dg) * SQ_W'(dg);
            r_a_sq_r <= SQ_W'(dr) * SQ_W'(dr);
        end
    end

    assign sq_dist = DIST_W'(r_a_sq_g) + DIST_W'(r_a_sq_r);

    always_ff @(posedge i_clk) begin
        if (a_ready && r_a_valid) begin
            r_b_nb  <= r_a_nb;
            r_b_ng  <= r_a_ng;
            r_b_nr  <= r_a_nr;
            r_b_hit <= RAD_W'(sq_dist) < i_cfg.radius_squared;
        end
    end

    assign o_valid      = r_b_valid;
    assign o_norm_blue  = r_b_nb;
    assign o_norm_green = r_b_ng;
    assign o_norm_red   = r_b_nr;
    assign o_in_target  = r_b_hit;

endmodule

// ----- hdl/chromaticity_color_classifier_core.sv -----
// ----------------------------------------------------------------------------
// chromaticity_color_classifier_core
// The core takes one BGR pixel per clock unless the result channel stalls,
// and returns its normalized chromaticity floor(c * 255 / (b + g + r)) per
// channel, zero for pixels whose channel sum is zero or below the dark
// threshold, together with a mask bit that is set when the normalized green
// and red lie strictly inside the configured target circle. Each pixel
// request yields exactly one result request, in order. Without a stall the
// sustained rate is one pixel per clock. The pipeline is one front stage,
// then the pipelined restoring divider stages, each resolving DIV_BITS
// quotient bits, and two stages for distance and compare. Every stage
// carries its own valid bit, so a stalled result does not stop the stages
// behind it from filling. Registers are to be written over the APB port
// only while no pixel is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module chromaticity_color_classifier_core import ccc_pkg::*; #(
    parameter int DIV_BITS = DIV_BITS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ccc_pix_if.sink               i_pix,
    ccc_res_if.source             o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int NUM_DIV = QUOT_W / DIV_BITS;

    t_cfg      r_cfg;
    t_reg_idx  reg_idx;
    logic      cfg_wr;

    t_div_item stg_item  [NUM_DIV+1];
    logic      stg_valid [NUM_DIV+1];
    logic      stg_ready [NUM_DIV+1];

    // Configuration registers.
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dark_threshold <= DARK_THRESHOLD_RST;
            r_cfg.target_green   <= TARGET_GREEN_RST;
            r_cfg.target_red     <= TARGET_RED_RST;
            r_cfg.radius_squared <= RADIUS_SQUARED_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_DARK_THRESHOLD: r_cfg.dark_threshold <= pwdata[THR_W-1:0];
                REG_TARGET_GREEN:   r_cfg.target_green   <= pwdata[TGT_W-1:0];
                REG_TARGET_RED:     r_cfg.target_red     <= pwdata[TGT_W-1:0];
                REG_RADIUS_SQUARED: r_cfg.radius_squared <= pwdata[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DARK_THRESHOLD: prdata = APB_DATA_W'(r_cfg.dark_threshold);
            REG_TARGET_GREEN:   prdata = APB_DATA_W'(r_cfg.target_green);
            REG_TARGET_RED:     prdata = APB_DATA_W'(r_cfg.target_red);
            REG_RADIUS_SQUARED: prdata = APB_DATA_W'(r_cfg.radius_squared);
            default:            prdata = '0;
        endcase
    end

    // Datapath.
    ccc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .i_blue  (i_pix.blue_in),
        .i_green (i_pix.green_in),
        .i_red   (i_pix.red_in),
        .i_cfg   (r_cfg),
        .o_ready (i_pix.ready),
        .o_valid (stg_valid[0]),
        .o_item  (stg_item[0]),
        .i_ready (stg_ready[0])
    );

    for (genvar s = 0; s < NUM_DIV; s++) begin : g_div
        ccc_div_stage #(
            .STAGE_IDX (s),
            .BITS      (DIV_BITS)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[s]),
            .i_item  (stg_item[s]),
            .o_ready (stg_ready[s]),
            .o_valid (stg_valid[s+1]),
            .o_item  (stg_item[s+1]),
            .i_ready (stg_ready[s+1])
        );
    end

    ccc_dist u_dist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (stg_valid[NUM_DIV]),
        .i_item       (stg_item[NUM_DIV]),
        .i_cfg        (r_cfg),
        .o_ready      (stg_ready[NUM_DIV]),
        .o_valid      (o_res.valid),
        .o_norm_blue  (o_res.norm_blue),
        .o_norm_green (o_res.norm_green),
        .o_norm_red   (o_res.norm_red),
        .o_in_target  (o_res.in_target),
        .i_ready      (o_res.ready)
    );

    // The floored shares of one pixel never add up to more than the scale.
    a_norm_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (SUM_W'(o_res.norm_blue) + SUM_W'(o_res.norm_green)
                         + SUM_W'(o_res.norm_red)) <= SUM_W'(NORM_SCALE))
        else $error("normalized channels exceed the scale");

    // A strict compare can never match against a zero radius.
    a_zero_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && r_cfg.radius_squared == '0) |-> !o_res.in_target)
        else $error("target match with zero radius");

    // A register write lands in the register that its address selects.
    a_cfg_green: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && reg_idx == REG_TARGET_GREEN)
            |=> r_cfg.target_green == $past(pwdata[TGT_W-1:0]))
        else $error("target green register write lost");

endmodule
